@@ sv/rect_line_clip_outcode_macros.svh @@
// Assertion macros for the line clipper.
// Included by the modules that check their own logic.
`ifndef RECT_LINE_CLIP_OUTCODE_MACROS_SVH
`define RECT_LINE_CLIP_OUTCODE_MACROS_SVH
`ifndef SYNTHESIS
`define RLC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RLC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLC_ASSERT(label, clk, rst_n, prop, msg)
`define RLC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ sv/rlc_pkg.sv @@
// Shared types and constants for the line clipper.
// No dependencies.
`timescale 1ns / 1ps
package rlc_pkg;
  localparam logic [3:0] CODE_U = 4'b0001;
  localparam logic [3:0] CODE_D = 4'b0010;
  localparam logic [3:0] CODE_R = 4'b0100;
  localparam logic [3:0] CODE_L = 4'b1000;
  localparam int unsigned MAX_PASSES = 16;
  localparam logic [1:0] REG_XMIN = 2'd0;
  localparam logic [1:0] REG_XMAX = 2'd1;
  localparam logic [1:0] REG_YMIN = 2'd2;
  localparam logic [1:0] REG_YMAX = 2'd3;
  // Divider and multiplier status toward the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

@@ sv/rlc_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rlc_pkg.
`timescale 1ns / 1ps
`include "rect_line_clip_outcode_macros.svh"
module rlc_div
  import rlc_pkg::*;
#(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output div_stat_t     stat_o,
  output logic [NW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   trial;

  // Shift one numerator bit into the remainder, try subtracting.
  always_comb begin
    trial  = {rem_q, quo_q[NW-1]} - {1'b0, den_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (go_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[DW]) begin
        rem_d = {rem_q[DW-2:0], quo_q[NW-1]};
        quo_d = {quo_q[NW-2:0], 1'b0};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (go_i) den_q <= den_i;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

  `RLC_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q), "done without busy")
  `RLC_ASSERT(a_no_busy_done, clk_i, rst_ni, !(busy_q && done_q), "busy and done together")
  `RLC_ASSERT(a_go_idle, clk_i, rst_ni, go_i |-> !busy_q, "start while busy")
endmodule

@@ sv/rlc_mul.sv @@
// Shift-add multiplier: one multiplier bit per cycle.
// Depends on rlc_pkg.
`timescale 1ns / 1ps
`include "rect_line_clip_outcode_macros.svh"
module rlc_mul
  import rlc_pkg::*;
#(
  parameter int unsigned AW = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [AW-1:0]   a_i,
  input  logic [AW-1:0]   b_i,
  output div_stat_t       stat_o,
  output logic [2*AW-1:0] prod_o
);
  localparam int unsigned CW = $clog2(AW + 1);
  logic [2*AW-1:0] acc_q, mcd_q;
  logic [AW-1:0]   mpr_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(AW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Add the shifted multiplicand when the low multiplier bit is set.
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      acc_q <= '0;
      mcd_q <= {{AW{1'b0}}, a_i};
      mpr_q <= b_i;
    end else if (busy_q) begin
      if (mpr_q[0]) acc_q <= acc_q + mcd_q;
      mcd_q <= {mcd_q[2*AW-2:0], 1'b0};
      mpr_q <= {1'b0, mpr_q[AW-1:1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

  `RLC_ASSERT(a_mdone_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q), "done without busy")
  `RLC_ASSERT(a_mno_overlap, clk_i, rst_ni, !(busy_q && done_q), "busy and done together")
  `RLC_ASSERT(a_mgo_idle, clk_i, rst_ni, go_i |-> !busy_q, "start while busy")
endmodule

@@ sv/rect_line_clip_outcode.sv @@
// From accept to strobe: up to MAX_PASSES clip passes, each clipping pass a bit-serial multiply
// then a bit-serial divide.
// Throughput: one segment at a time; busy_o is high from accept through the
// strobe, so the next start is taken the cycle after the strobe.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset: asynchronous, active low; window bounds return to full range.
`timescale 1ns / 1ps
`include "rect_line_clip_outcode_macros.svh"
module rect_line_clip_outcode
  import rlc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  output logic                          done_o,
  output logic                          verdict_o,
  output logic signed [COORD_WIDTH-1:0] clip_ax_o,
  output logic signed [COORD_WIDTH-1:0] clip_ay_o,
  output logic signed [COORD_WIDTH-1:0] clip_bx_o,
  output logic signed [COORD_WIDTH-1:0] clip_by_o
);
  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned EW = W + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned PC = $clog2(MAX_PASSES + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TEST = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic signed [W-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [W-1:0] xl, xh, yl, yh;
  logic [PC-1:0]       pass_q;
  logic                rej_q, neg_q, axis_y_q;
  logic signed [W-1:0] edge_q;
  logic signed [EW-1:0] base_q;
  logic [EW-1:0]       ud_q, un_q, udn_q;
  logic [3:0]          c1, c2;
  logic                wr;

  // Register file.
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmin_q <= {1'b1, {(W-1){1'b0}}};
      xmax_q <= {1'b0, {(W-1){1'b1}}};
      ymin_q <= {1'b1, {(W-1){1'b0}}};
      ymax_q <= {1'b0, {(W-1){1'b1}}};
    end else if (wr) begin
      case (paddr[3:2])
        REG_XMIN: xmin_q <= pwdata[W-1:0];
        REG_XMAX: xmax_q <= pwdata[W-1:0];
        REG_YMIN: ymin_q <= pwdata[W-1:0];
        REG_YMAX: ymax_q <= pwdata[W-1:0];
        default:  ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      REG_XMIN: prdata = 32'(signed'(xmin_q));
      REG_XMAX: prdata = 32'(signed'(xmax_q));
      REG_YMIN: prdata = 32'(signed'(ymin_q));
      REG_YMAX: prdata = 32'(signed'(ymax_q));
      default:  prdata = '0;
    endcase
  end

  // Ordered bounds.
  assign xl = (xmin_q < xmax_q) ? xmin_q : xmax_q;
  assign xh = (xmin_q < xmax_q) ? xmax_q : xmin_q;
  assign yl = (ymin_q < ymax_q) ? ymin_q : ymax_q;
  assign yh = (ymin_q < ymax_q) ? ymax_q : ymin_q;

  function automatic logic [3:0] ocode(logic signed [W-1:0] x, logic signed [W-1:0] y,
      logic signed [W-1:0] l_x, logic signed [W-1:0] h_x,
      logic signed [W-1:0] l_y, logic signed [W-1:0] h_y);
    logic [3:0] c;
    c = '0;
    if (y < l_y) c |= CODE_U;
    if (y > h_y) c |= CODE_D;
    if (x > h_x) c |= CODE_R;
    if (x < l_x) c |= CODE_L;
    return c;
  endfunction

  assign c1 = ocode(x1_q, y1_q, xl, xh, yl, yh);
  assign c2 = ocode(x2_q, y2_q, xl, xh, yl, yh);

  // Serial arithmetic units; the multiplier starts once its operands are registered.
  div_stat_t        mst, dst;
  logic             mgo, mgo_q, dgo;
  logic [PW-1:0]    prod, quo;

  rlc_mul #(.AW(EW)) u_mul (
    .clk_i, .rst_ni, .go_i(mgo_q), .a_i(ud_q), .b_i(un_q), .stat_o(mst), .prod_o(prod)
  );
  rlc_div #(.NW(PW), .DW(EW)) u_div (
    .clk_i, .rst_ni, .go_i(dgo), .num_i(prod), .den_i(udn_q), .stat_o(dst), .quo_o(quo)
  );

  // Swap-aware view of the endpoints for this pass.
  logic signed [W-1:0] ax, ay, bx, by;
  logic [3:0]          ca;
  logic signed [EW-1:0] d, n, dn;
  logic                sel_y, act;
  logic signed [W-1:0] edg;
  always_comb begin
    if (c1 == '0) begin
      ax = x2_q; ay = y2_q; bx = x1_q; by = y1_q; ca = c2;
    end else begin
      ax = x1_q; ay = y1_q; bx = x2_q; by = y2_q; ca = c1;
    end
    act   = 1'b1;
    sel_y = 1'b1;
    edg   = yl;
    if ((ca & CODE_U) != '0 && by != ay) begin
      edg = yl;
    end else if ((ca & CODE_D) != '0 && by != ay) begin
      edg = yh;
    end else if ((ca & CODE_R) != '0 && bx != ax) begin
      sel_y = 1'b0; edg = xh;
    end else if ((ca & CODE_L) != '0 && bx != ax) begin
      sel_y = 1'b0; edg = xl;
    end else begin
      act = 1'b0;
    end
    if (sel_y) begin
      d  = EW'(bx) - EW'(ax);
      n  = EW'(edg) - EW'(ay);
      dn = EW'(by) - EW'(ay);
    end else begin
      d  = EW'(by) - EW'(ay);
      n  = EW'(edg) - EW'(ax);
      dn = EW'(bx) - EW'(ax);
    end
  end

  logic signed [PW:0]  lr;
  logic signed [W-1:0] newc;
  assign lr   = neg_q ? ((PW+1)'(base_q) - (PW+1)'(quo)) : ((PW+1)'(base_q) + (PW+1)'(quo));
  assign newc = lr[W-1:0];

  logic [PC-1:0] pass_d;
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    mgo = 1'b0;
    dgo = 1'b0;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_TEST;
      ST_TEST: begin
        if ((c1 & c2) != '0 || pass_q == PC'(MAX_PASSES)) state_d = ST_OUT;
        else if (c1 == '0 && c2 == '0) state_d = ST_OUT;
        else if (!act) pass_d = pass_q + 1'b1;
        else begin
          state_d = ST_MUL;
          mgo     = 1'b1;
        end
      end
      ST_MUL: if (mst.done) begin
        state_d = ST_DIV;
        dgo     = 1'b1;
      end
      ST_DIV: if (dst.done) begin
        state_d = ST_TEST;
        pass_d  = pass_q + 1'b1;
      end
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= '0;
      rej_q   <= 1'b0;
      mgo_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= (state_q == ST_IDLE) ? '0 : pass_d;
      mgo_q   <= mgo;
      // pass limit reached counts as reject
      if (state_q == ST_TEST) begin
        rej_q <= (pass_q == PC'(MAX_PASSES)) || !(c1 == '0 && c2 == '0);
      end
    end
  end

  // Endpoint datapath.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      x1_q <= start_x_i; y1_q <= start_y_i; x2_q <= end_x_i; y2_q <= end_y_i;
    end else if (state_q == ST_TEST && (c1 & c2) == '0 && (c1 != '0 || c2 != '0)) begin
      x1_q <= ax; y1_q <= ay; x2_q <= bx; y2_q <= by;
      ud_q   <= d[EW-1] ? EW'(-d) : d;
      un_q   <= n[EW-1] ? EW'(-n) : n;
      udn_q  <= dn[EW-1] ? EW'(-dn) : dn;
      neg_q  <= d[EW-1] ^ n[EW-1] ^ dn[EW-1];
      axis_y_q <= sel_y;
      edge_q <= edg;
      base_q <= sel_y ? EW'(ax) : EW'(ay);
    end else if (state_q == ST_DIV && dst.done) begin
      if (axis_y_q) begin
        x1_q <= newc; y1_q <= edge_q;
      end else begin
        y1_q <= newc; x1_q <= edge_q;
      end
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign done_o    = (state_q == ST_OUT);
  assign verdict_o = rej_q;
  assign clip_ax_o = rej_q ? '0 : x1_q;
  assign clip_ay_o = rej_q ? '0 : y1_q;
  assign clip_bx_o = rej_q ? '0 : x2_q;
  assign clip_by_o = rej_q ? '0 : y2_q;

  `RLC_ASSERT(a_out_one_cycle, clk_i, rst_ni, done_o |=> !done_o, "strobe longer than one cycle")
  `RLC_ASSERT(a_out_from_test, clk_i, rst_ni, done_o |-> $past(state_q == ST_TEST), "strobe not after test")
  `RLC_ASSERT(a_div_after_mul, clk_i, rst_ni, dgo |-> mst.done, "divide without product")
  `RLC_ASSERT_ALWAYS(a_onehot, clk_i, $onehot(state_q) || !rst_ni, "state not one-hot")
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the rectangular line clipper.
// Depends on rlc_pkg and rect_line_clip_outcode; predicts each clip in place.
`timescale 1ns / 1ps
module testbench;
  import rlc_pkg::*;

  localparam int W = 16;
  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 400;

  typedef struct {
    logic           verdict;
    logic [W-1:0]   ax, ay, bx, by;
  } clip_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start_i = 1'b0;
  logic busy_o, done_o, verdict_o;
  logic signed [W-1:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic signed [W-1:0] clip_ax_o, clip_ay_o, clip_bx_o, clip_by_o;

  // window copy and pending expectations
  logic signed [W-1:0] win_xmin, win_xmax, win_ymin, win_ymax;
  clip_t expected_clips[$];
  int errors = 0;
  int idle_cycles = 0;
  int idle_pct = 0;

  always #5 clk_i = ~clk_i;

  rect_line_clip_outcode #(.COORD_WIDTH(W)) DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start_i, .busy_o, .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .done_o, .verdict_o, .clip_ax_o, .clip_ay_o, .clip_bx_o, .clip_by_o
  );

  function automatic logic [3:0] region_code(longint x, longint y, longint xl,
                                             longint xh, longint yl, longint yh);
    logic [3:0] c;
    c = '0;
    if (y < yl) c |= CODE_U;
    if (y > yh) c |= CODE_D;
    if (x > xh) c |= CODE_R;
    if (x < xl) c |= CODE_L;
    return c;
  endfunction

  // a + (b-a)*num/den with truncation toward zero
  function automatic longint edge_point(longint a, longint b, longint num, longint den);
    longint p;
    longint q;
    p = (b - a) * num;
    if (den == 0) return a;
    q = (p < 0 ? -p : p) / (den < 0 ? -den : den);
    return ((p < 0) != (den < 0)) ? a - q : a + q;
  endfunction

  function automatic clip_t clip_segment(longint x1, longint y1, longint x2, longint y2);
    longint xl, xh, yl, yh, t;
    logic [3:0] c1, c2;
    logic rejected;
    clip_t r;
    xl = (win_xmin < win_xmax) ? win_xmin : win_xmax;
    xh = (win_xmin < win_xmax) ? win_xmax : win_xmin;
    yl = (win_ymin < win_ymax) ? win_ymin : win_ymax;
    yh = (win_ymin < win_ymax) ? win_ymax : win_ymin;
    rejected = 1'b1;
    for (int pass = 0; pass < MAX_PASSES; pass++) begin
      c1 = region_code(x1, y1, xl, xh, yl, yh);
      c2 = region_code(x2, y2, xl, xh, yl, yh);
      if ((c1 & c2) != 0) break;
      if (c1 == 0 && c2 == 0) begin
        rejected = 1'b0;
        break;
      end
      if (c1 == 0) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
        c1 = c2;
      end
      if ((c1 & CODE_U) != 0 && y2 != y1) begin
        x1 = edge_point(x1, x2, yl - y1, y2 - y1); y1 = yl;
      end else if ((c1 & CODE_D) != 0 && y2 != y1) begin
        x1 = edge_point(x1, x2, yh - y1, y2 - y1); y1 = yh;
      end else if ((c1 & CODE_R) != 0 && x2 != x1) begin
        y1 = edge_point(y1, y2, xh - x1, x2 - x1); x1 = xh;
      end else if ((c1 & CODE_L) != 0 && x2 != x1) begin
        y1 = edge_point(y1, y2, xl - x1, x2 - x1); x1 = xl;
      end
    end
    r.verdict = rejected;
    r.ax = rejected ? '0 : x1[W-1:0];
    r.ay = rejected ? '0 : y1[W-1:0];
    r.bx = rejected ? '0 : x2[W-1:0];
    r.by = rejected ? '0 : y2[W-1:0];
    return r;
  endfunction

  // register write over APB, setup then access
  task automatic write_bound(logic [1:0] idx, logic signed [W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {{(32-W){val[W-1]}}, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_XMIN: win_xmin = val;
      REG_XMAX: win_xmax = val;
      REG_YMIN: win_ymin = val;
      default:  win_ymax = val;
    endcase
  endtask

  task automatic set_window(int xl, int xh, int yl, int yh);
    write_bound(REG_XMIN, xl[W-1:0]);
    write_bound(REG_XMAX, xh[W-1:0]);
    write_bound(REG_YMIN, yl[W-1:0]);
    write_bound(REG_YMAX, yh[W-1:0]);
  endtask

  // one segment transaction; start held until busy_o drops
  task automatic send_segment(int x1, int y1, int x2, int y2);
    do @(negedge clk_i); while (idle_pct != 0 && $urandom_range(99) < idle_pct);
    start_x_i <= x1[W-1:0]; start_y_i <= y1[W-1:0];
    end_x_i <= x2[W-1:0]; end_y_i <= y2[W-1:0];
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_clips.insert(expected_clips.size(),
                          clip_segment(signed'(x1[W-1:0]), signed'(y1[W-1:0]),
                                       signed'(x2[W-1:0]), signed'(y2[W-1:0])));
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (expected_clips.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(400) - 200;
      2: return $urandom_range(1) ? 32767 : -32768;
      default: return $urandom_range(3000) - 1500;
    endcase
  endfunction

  task automatic test_directed();
    set_window(-100, 100, -50, 50);
    send_segment(0, 0, 10, 10);            // fully inside
    send_segment(-200, 0, 200, 0);         // crosses xmin and xmax
    send_segment(0, -200, 0, 200);         // crosses ymin and ymax
    send_segment(-200, -200, 200, 200);    // diagonal, clipped at ymin and ymax
    send_segment(150, 60, 300, 70);        // trivially outside
    send_segment(-300, 80, 300, -90);      // straddles, partial
    send_segment(5, 5, 5, 5);              // point inside
    send_segment(500, 5, 500, 5);          // point outside
    send_segment(0, 0, 400, 30);           // first point inside, swap
    send_segment(-150, 60, 150, 90);       // both ends past ymax, trivially outside
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    wait_quiet();
    set_window(100, -100, 50, -50);        // swapped bounds
    send_segment(-200, 10, 200, -10);
    send_segment(-32768, 0, 32767, 0);
    wait_quiet();
    set_window(-32768, 32767, -32768, 32767);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, 32767, 32767, 32767);
    wait_quiet();
    set_window(32767, 32767, -32768, -32768); // degenerate window at extremes
    send_segment(0, 0, 32767, -32768);
    send_segment(32767, -32768, 32767, -32768);
    wait_quiet();
  endtask

  task automatic test_random(int pct, int count);
    int xl, xh, yl, yh;
    idle_pct = pct;
    xl = $urandom_range(4000) - 2000; xh = xl + $urandom_range(4000);
    yl = $urandom_range(4000) - 2000; yh = yl + $urandom_range(4000);
    if ($urandom_range(3) == 0) set_window(xh, xl, yh, yl);
    else set_window(xl, xh, yl, yh);
    repeat (count) send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    wait_quiet();
  endtask

  // result checker
  always @(posedge clk_i) begin
    clip_t exp_c;
    if (rst_ni && done_o) begin
      if (expected_clips.size() == 0) begin
        $display("%0t: unexpected result verdict=%0b", $time, verdict_o);
        errors++;
      end else begin
        exp_c = expected_clips.pop_front();
        if (verdict_o !== exp_c.verdict || clip_ax_o !== exp_c.ax ||
            clip_ay_o !== exp_c.ay || clip_bx_o !== exp_c.bx ||
            clip_by_o !== exp_c.by) begin
          $display("%0t: expected v=%0b a=(%0d,%0d) b=(%0d,%0d) got v=%0b a=(%0d,%0d) b=(%0d,%0d)",
                   $time, exp_c.verdict, $signed(exp_c.ax), $signed(exp_c.ay),
                   $signed(exp_c.bx), $signed(exp_c.by), verdict_o, clip_ax_o,
                   clip_ay_o, clip_bx_o, clip_by_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without a transaction
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    win_xmin = -32768; win_xmax = 32767; win_ymin = -32768; win_ymax = 32767;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_segment(-40000, 5, 40000, -5);    // reset window check
    wait_quiet();
    test_directed();
    test_random(0, 160);
    test_random(54, 160);
    test_random(31, 160);
    test_random(0, 150);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule
